// ----- hdl/acc_isa_pkg.sv -----
// ============================================================================
// acc_isa_pkg
// Opcodes, status codes and the controller/datapath interface types shared
// by the accumulator instruction executor.
// ============================================================================
package acc_isa_pkg;

    localparam logic [5:0] OP_LOAD_MEM   = 6'd0;
    localparam logic [5:0] OP_LOAD_IMM   = 6'd1;
    localparam logic [5:0] OP_STORE      = 6'd2;
    localparam logic [5:0] OP_ADD_MEM    = 6'd3;
    localparam logic [5:0] OP_ADD_IMM    = 6'd4;
    localparam logic [5:0] OP_SUB_MEM    = 6'd5;
    localparam logic [5:0] OP_SUB_IMM    = 6'd6;
    localparam logic [5:0] OP_MUL_MEM    = 6'd7;
    localparam logic [5:0] OP_MUL_IMM    = 6'd8;
    localparam logic [5:0] OP_DIV_MEM    = 6'd9;
    localparam logic [5:0] OP_DIV_IMM    = 6'd10;
    localparam logic [5:0] OP_REM_MEM    = 6'd11;
    localparam logic [5:0] OP_REM_IMM    = 6'd12;
    localparam logic [5:0] OP_SHL_MEM    = 6'd13;
    localparam logic [5:0] OP_SHL_IMM    = 6'd14;
    localparam logic [5:0] OP_SHR_MEM    = 6'd15;
    localparam logic [5:0] OP_SHR_IMM    = 6'd16;
    localparam logic [5:0] OP_OR_MEM     = 6'd17;
    localparam logic [5:0] OP_OR_IMM     = 6'd18;
    localparam logic [5:0] OP_AND_MEM    = 6'd19;
    localparam logic [5:0] OP_AND_IMM    = 6'd20;
    localparam logic [5:0] OP_XOR_MEM    = 6'd21;
    localparam logic [5:0] OP_XOR_IMM    = 6'd22;
    localparam logic [5:0] OP_NOT        = 6'd23;
    localparam logic [5:0] OP_CALL_MEM   = 6'd24;
    localparam logic [5:0] OP_CALL_IMM   = 6'd25;
    localparam logic [5:0] OP_CALLZ_MEM  = 6'd26;
    localparam logic [5:0] OP_CALLZ_IMM  = 6'd27;
    localparam logic [5:0] OP_CALLN_MEM  = 6'd28;
    localparam logic [5:0] OP_CALLN_IMM  = 6'd29;
    localparam logic [5:0] OP_RET        = 6'd30;
    localparam logic [5:0] OP_BR_MEM     = 6'd31;
    localparam logic [5:0] OP_BR_IMM     = 6'd32;
    localparam logic [5:0] OP_BRZ_MEM    = 6'd33;
    localparam logic [5:0] OP_BRZ_IMM    = 6'd34;
    localparam logic [5:0] OP_NOP        = 6'd35;
    localparam logic [5:0] OP_HALT       = 6'd36;
    localparam logic [5:0] OP_CLR_FLAGS  = 6'd37;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_HALTED   = 3'd1;
    localparam logic [2:0] STAT_DIV_ZERO = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;

    localparam logic [7:0]  PTR_STEP = 8'd4;
    localparam logic [31:0] PC_STEP  = 32'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC,
        ST_READ,
        ST_EXEC,
        ST_WRITE,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic cnt_clear;
        logic cnt_inc;
        logic rd_capture;
        logic wr_en;
        logic exec;
        logic div_start;
        logic div_wb;
        logic out_load;
        logic clr_step;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       need_rd;
        logic       need_wr;
        logic       div_go;
        logic       div_done;
        logic [2:0] cnt;
    } dp_stat_t;

    // Operand comes from the memory word at the body address.
    function automatic logic is_mem_form(input logic [5:0] op);
        return (op == OP_LOAD_MEM) || (op == OP_ADD_MEM) || (op == OP_SUB_MEM) ||
               (op == OP_MUL_MEM) || (op == OP_DIV_MEM) || (op == OP_REM_MEM) ||
               (op == OP_SHL_MEM) || (op == OP_SHR_MEM) || (op == OP_OR_MEM) ||
               (op == OP_AND_MEM) || (op == OP_XOR_MEM) || (op == OP_CALL_MEM) ||
               (op == OP_CALLZ_MEM) || (op == OP_CALLN_MEM) || (op == OP_BR_MEM) ||
               (op == OP_BRZ_MEM);
    endfunction

endpackage

// ----- hdl/acc_isa_ram.sv -----
// ============================================================================
// acc_isa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module acc_isa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hdl/acc_isa_div.sv -----
// ============================================================================
// acc_isa_div
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ============================================================================
module acc_isa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        qbit;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        qbit      = (trial >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? 32'(trial - {1'b0, divisor}) : trial[31:0];
            quo_next = {quo_reg[30:0], qbit};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- hdl/acc_isa_dp.sv -----
// ============================================================================
// acc_isa_dp
// Datapath: register file, PC, SP, flags, byte memory, ALU, divider and the
// output registers. Driven by command bits from the controller.
// ============================================================================
module acc_isa_dp #(
    parameter int NUM_REGS    = 8,
    parameter int MEM_BYTES   = 256,
    parameter int STACK_LIMIT = 252,
    parameter int STACK_BASE  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  acc_isa_pkg::dp_cmd_t  cmd,
    output acc_isa_pkg::dp_stat_t stat,
    input  logic [5:0]          opcode,
    input  logic [2:0]          reg_index,
    input  logic [31:0]         body,
    output logic [2:0]          status,
    output logic [31:0]         next_pc,
    output logic [7:0]          stack_ptr,
    output logic                zero_flag,
    output logic                neg_flag,
    output logic                ovf_flag,
    output logic [31:0]         reg_value
);
    import acc_isa_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int RIDX_W = $clog2(NUM_REGS);

    function automatic logic [RIDX_W-1:0] reg_sel(input logic [2:0] idx);
        logic [4:0] v;
        v = {2'b00, idx};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 5'(NUM_REGS))
            begin
                v = v - 5'(NUM_REGS);
            end
        end
        return RIDX_W'(v);
    endfunction

    logic [5:0]        op_reg;
    logic [RIDX_W-1:0] ri_reg;
    logic [31:0]       body_reg;
    logic [31:0]       gp_reg [NUM_REGS];
    logic [31:0]       pc_reg;
    logic [7:0]        sp_reg;
    logic              z_reg, n_reg, v_reg;
    logic [31:0]       word_reg;
    logic [2:0]        status_reg;
    logic [ADDR_W-1:0] wr_base_reg;
    logic [31:0]       wr_data_reg;
    logic [2:0]        cnt_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [2:0]        out_status_reg;
    logic [31:0]       out_pc_reg;
    logic [7:0]        out_sp_reg;
    logic              out_z_reg, out_n_reg, out_v_reg;
    logic [31:0]       out_reg_value_reg;

    logic [31:0]       old, opnd, pc_plus4;
    logic [7:0]        sp_dec, sp_inc;
    logic [ADDR_W-1:0] rd_base;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              ram_we;
    logic              full, empty, call_cond, is_call, is_div;

    // Execute results
    logic [31:0]       alu_res, ex_pc;
    logic              ex_wr_gp, ex_set_zn, ex_set_v, ex_v, ex_clr_flags;
    logic [2:0]        ex_status;
    logic [7:0]        ex_sp;
    logic              ex_need_wr;
    logic [ADDR_W-1:0] ex_wr_base;
    logic [31:0]       ex_wr_data;
    logic [31:0]       sum, diff, prod;

    logic              div_done;
    logic [31:0]       div_q, div_r, div_res;

    assign old      = gp_reg[ri_reg];
    assign opnd     = is_mem_form(op_reg) ? word_reg : body_reg;
    assign pc_plus4 = pc_reg + PC_STEP;
    assign sp_dec   = sp_reg - PTR_STEP;
    assign sp_inc   = sp_reg + PTR_STEP;
    assign full     = ({24'd0, sp_reg} >= 32'(STACK_LIMIT));
    assign empty    = ({24'd0, sp_reg} <= 32'(STACK_BASE));
    assign rd_base  = (op_reg == OP_RET) ? ADDR_W'(sp_dec) : body_reg[ADDR_W-1:0];
    assign is_div   = (op_reg >= OP_DIV_MEM) && (op_reg <= OP_REM_IMM);
    assign is_call  = (op_reg >= OP_CALL_MEM) && (op_reg <= OP_CALLN_IMM);

    always_comb
    begin
        call_cond = 1'b1;
        if ((op_reg == OP_CALLZ_MEM) || (op_reg == OP_CALLZ_IMM))
        begin
            call_cond = z_reg;
        end
        else if ((op_reg == OP_CALLN_MEM) || (op_reg == OP_CALLN_IMM))
        begin
            call_cond = n_reg;
        end
    end

    assign sum  = old + opnd;
    assign diff = old - opnd;
    assign prod = old * opnd;

    always_comb
    begin
        alu_res      = '0;
        ex_pc        = pc_plus4;
        ex_wr_gp     = 1'b0;
        ex_set_zn    = 1'b0;
        ex_set_v     = 1'b0;
        ex_v         = 1'b0;
        ex_clr_flags = 1'b0;
        ex_status    = STAT_OK;
        ex_sp        = sp_reg;
        ex_need_wr   = 1'b0;
        ex_wr_base   = body_reg[ADDR_W-1:0];
        ex_wr_data   = old;
        case (op_reg)
            OP_LOAD_MEM, OP_LOAD_IMM:
            begin
                alu_res  = opnd;
                ex_wr_gp = 1'b1;
            end
            OP_STORE:
            begin
                ex_need_wr = 1'b1;
            end
            OP_ADD_MEM, OP_ADD_IMM:
            begin
                alu_res = sum; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
                ex_set_v = 1'b1; ex_v = (old > sum);
            end
            OP_SUB_MEM, OP_SUB_IMM:
            begin
                alu_res = diff; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
                ex_set_v = 1'b1; ex_v = (old < diff);
            end
            OP_MUL_MEM, OP_MUL_IMM:
            begin
                alu_res = prod; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
                ex_set_v = 1'b1; ex_v = (old > prod);
            end
            OP_DIV_MEM, OP_DIV_IMM, OP_REM_MEM, OP_REM_IMM:
            begin
                // A nonzero divisor finishes in the divider.
                if (opnd == 32'd0)
                begin
                    ex_status = STAT_DIV_ZERO;
                end
            end
            OP_SHL_MEM, OP_SHL_IMM:
            begin
                alu_res = (opnd >= 32'd32) ? 32'd0 : (old << opnd[4:0]);
                ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
            end
            OP_SHR_MEM, OP_SHR_IMM:
            begin
                alu_res = (opnd >= 32'd32) ? 32'd0 : (old >> opnd[4:0]);
                ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
            end
            OP_OR_MEM, OP_OR_IMM:
            begin
                alu_res = old | opnd; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
            end
            OP_AND_MEM, OP_AND_IMM:
            begin
                alu_res = old & opnd; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
            end
            OP_XOR_MEM, OP_XOR_IMM:
            begin
                alu_res = old ^ opnd; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
            end
            OP_NOT:
            begin
                alu_res = ~old; ex_wr_gp = 1'b1; ex_set_zn = 1'b1;
            end
            OP_CALL_MEM, OP_CALL_IMM, OP_CALLZ_MEM, OP_CALLZ_IMM,
            OP_CALLN_MEM, OP_CALLN_IMM:
            begin
                if (call_cond)
                begin
                    if (full)
                    begin
                        ex_status = STAT_FULL;
                    end
                    else
                    begin
                        ex_need_wr = 1'b1;
                        ex_wr_base = ADDR_W'(sp_reg);
                        ex_wr_data = pc_plus4;
                        ex_sp      = sp_inc;
                        ex_pc      = opnd;
                    end
                end
            end
            OP_RET:
            begin
                if (empty)
                begin
                    ex_status = STAT_EMPTY;
                end
                else
                begin
                    ex_need_wr = 1'b1;
                    ex_wr_base = ADDR_W'(sp_dec);
                    ex_wr_data = '0;
                    ex_sp      = sp_dec;
                    ex_pc      = word_reg;
                end
            end
            OP_BR_MEM, OP_BR_IMM:
            begin
                ex_pc = opnd;
            end
            OP_BRZ_MEM, OP_BRZ_IMM:
            begin
                if (z_reg)
                begin
                    ex_pc = opnd;
                end
            end
            OP_HALT:
            begin
                ex_status = STAT_HALTED;
            end
            OP_CLR_FLAGS:
            begin
                ex_clr_flags = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign div_res = (op_reg <= OP_DIV_IMM) ? div_q : div_r;

    acc_isa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (old),
        .divisor   (opnd),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Byte memory port selection.
    assign ram_we    = cmd.clr_step | cmd.wr_en;
    assign ram_waddr = cmd.clr_step ? clr_reg : (wr_base_reg + ADDR_W'(cnt_reg[1:0]));
    assign ram_wdata = cmd.clr_step ? 8'd0 : 8'(wr_data_reg >> {cnt_reg[1:0], 3'b000});
    assign ram_raddr = rd_base + ADDR_W'(cnt_reg[1:0]);

    acc_isa_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                gp_reg[i] <= '0;
            end
            pc_reg  <= '0;
            sp_reg  <= 8'(STACK_BASE);
            z_reg   <= 1'b0;
            n_reg   <= 1'b0;
            v_reg   <= 1'b0;
            cnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (cmd.exec && !stat.div_go)
            begin
                if (ex_wr_gp)
                begin
                    gp_reg[ri_reg] <= alu_res;
                end
                if (ex_set_zn)
                begin
                    z_reg <= (alu_res == 32'd0);
                    n_reg <= alu_res[31];
                end
                if (ex_set_v)
                begin
                    v_reg <= ex_v;
                end
                if (ex_clr_flags)
                begin
                    z_reg <= 1'b0;
                    n_reg <= 1'b0;
                    v_reg <= 1'b0;
                end
                if (ex_status == STAT_OK)
                begin
                    pc_reg <= ex_pc;
                end
                sp_reg <= ex_sp;
            end
            if (cmd.div_wb)
            begin
                gp_reg[ri_reg] <= div_res;
                z_reg          <= (div_res == 32'd0);
                n_reg          <= div_res[31];
                pc_reg         <= pc_plus4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= opcode;
            ri_reg   <= reg_sel(reg_index);
            body_reg <= body;
        end
        if (cmd.rd_capture && (cnt_reg != 3'd0))
        begin
            // Little-endian: bytes shift in from the top.
            word_reg <= {ram_rdata, word_reg[31:8]};
        end
        if (cmd.exec)
        begin
            status_reg  <= ex_status;
            wr_base_reg <= ex_wr_base;
            wr_data_reg <= ex_wr_data;
        end
        if (cmd.out_load)
        begin
            out_status_reg    <= status_reg;
            out_pc_reg        <= pc_reg;
            out_sp_reg        <= sp_reg;
            out_z_reg         <= z_reg;
            out_n_reg         <= n_reg;
            out_v_reg         <= v_reg;
            out_reg_value_reg <= gp_reg[ri_reg];
        end
    end

    always_comb
    begin
        stat.clr_done = &clr_reg;
        stat.need_rd  = is_mem_form(op_reg) || ((op_reg == OP_RET) && !empty);
        stat.need_wr  = ex_need_wr;
        stat.div_go   = is_div && (opnd != 32'd0);
        stat.div_done = div_done;
        stat.cnt      = cnt_reg;
    end

    assign status    = out_status_reg;
    assign next_pc   = out_pc_reg;
    assign stack_ptr = out_sp_reg;
    assign zero_flag = out_z_reg;
    assign neg_flag  = out_n_reg;
    assign ovf_flag  = out_v_reg;
    assign reg_value = out_reg_value_reg;

    logic unused_call;
    assign unused_call = is_call;
endmodule

// ----- hdl/acc_isa_ctrl.sv -----
// ============================================================================
// acc_isa_ctrl
// Controller: sequences memory clear, decode, word read, execute, word write,
// divide and result hand-off; owns the handshake flags.
// ============================================================================
module acc_isa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  acc_isa_pkg::dp_stat_t stat,
    output acc_isa_pkg::dp_cmd_t  cmd
);
    import acc_isa_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in  = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_DEC;
                end
            end
            ST_DEC:
            begin
                state_next = stat.need_rd ? ST_READ : ST_EXEC;
            end
            ST_READ:
            begin
                // Read data is registered and appears in the cycle after its address.
                cmd.rd_capture = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (stat.cnt == 3'd4)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.div_go)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (stat.need_wr)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_WRITE;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt == 3'd3)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_wb = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ----- hdl/accumulator_isa_executor_top.sv -----
// ============================================================================
// accumulator_isa_executor_top
// Accumulator-style instruction executor: one result transfer per
// instruction transfer, with register file, PC, SP, flags and byte memory.
// ============================================================================
//
//   Channel | Handshake           | Payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid / in_ready | opcode, reg_index, body
//   out     | out_valid/out_ready | status, next_pc, stack_ptr, zero_flag,
//           |                     | neg_flag, ovf_flag, reg_value
//
// An instruction is decoded, executed and handed off, with a word read and
// a word write added when it reads or writes memory; the byte memory moves
// one byte per cycle. Divide and remainder also use the bit-serial divider.
// After reset the byte memory is cleared one byte per cycle with in_ready
// low. MEM_BYTES must be a power of two; the block does not check it.
// A result waits in the output register while the next instruction is taken;
// that instruction finishes once the waiting result has been transferred.
module accumulator_isa_executor_top #(
    parameter int NUM_REGS    = 8,
    parameter int MEM_BYTES   = 256,
    parameter int STACK_LIMIT = 252,
    parameter int STACK_BASE  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  opcode,
    input  logic [2:0]  reg_index,
    input  logic [31:0] body,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] next_pc,
    output logic [7:0]  stack_ptr,
    output logic        zero_flag,
    output logic        neg_flag,
    output logic        ovf_flag,
    output logic [31:0] reg_value
);
    import acc_isa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    acc_isa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    acc_isa_dp #(
        .NUM_REGS    (NUM_REGS),
        .MEM_BYTES   (MEM_BYTES),
        .STACK_LIMIT (STACK_LIMIT),
        .STACK_BASE  (STACK_BASE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (opcode),
        .reg_index (reg_index),
        .body      (body),
        .status    (status),
        .next_pc   (next_pc),
        .stack_ptr (stack_ptr),
        .zero_flag (zero_flag),
        .neg_flag  (neg_flag),
        .ovf_flag  (ovf_flag),
        .reg_value (reg_value)
    );
endmodule

// ----- hdl/acc_isa_chk.sv -----
// ============================================================================
// acc_isa_chk
// Port-level checks for the instruction executor, bound to the top level.
// ============================================================================
module acc_isa_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [5:0]  opcode,
    input logic [2:0]  reg_index,
    input logic [31:0] body,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] next_pc,
    input logic [7:0]  stack_ptr,
    input logic        zero_flag,
    input logic        neg_flag,
    input logic        ovf_flag,
    input logic [31:0] reg_value
);
    import acc_isa_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // At most one instruction in work beside one waiting result.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two instructions outstanding");

    // Every result transfer answers an earlier instruction transfer.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without instruction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_HALTED ||
                       status == STAT_DIV_ZERO || status == STAT_FULL ||
                       status == STAT_EMPTY))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) &&
                                    $stable(reg_value) && $stable(status))
        else $error("result changed while stalled");

    logic unused_ok;
    assign unused_ok = ^{opcode, reg_index, body, stack_ptr, zero_flag, neg_flag, ovf_flag};
endmodule

bind accumulator_isa_executor_top acc_isa_chk u_acc_isa_chk (.*);

// ----- sim/accumulator_isa_executor_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Executor result checker
// Watches both channels of the instruction executor. It keeps its own copy of
// the registers, PC, SP, flags and byte memory, computes the expected result
// of every instruction transfer, and compares each result transfer with it.
// ----------------------------------------------------------------------------
module accumulator_isa_executor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [5:0]  opcode,
    input  logic [2:0]  reg_index,
    input  logic [31:0] body,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] next_pc,
    input  logic [7:0]  stack_ptr,
    input  logic        zero_flag,
    input  logic        neg_flag,
    input  logic        ovf_flag,
    input  logic [31:0] reg_value,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    import acc_isa_pkg::*;

    localparam int          STACK_LIMIT = 252;
    localparam logic [7:0]  STACK_BASE  = 8'd16;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pc;
        logic [7:0]  sp;
        logic        z;
        logic        n;
        logic        v;
        logic [31:0] rv;
    } exec_result_t;

    logic [31:0] regs [8];
    logic [7:0]  mem [256];
    logic [31:0] pc;
    logic [7:0]  sp;
    logic        zf, nf, vf;
    exec_result_t expected_results[$];

    function automatic logic [31:0] read_word(logic [31:0] addr);
        logic [31:0] w;
        w = 0;
        for (int i = 0; i < 4; i++)
            w[8*i +: 8] = mem[8'(addr + i)];
        return w;
    endfunction

    task automatic write_word(logic [31:0] addr, logic [31:0] w);
        for (int i = 0; i < 4; i++)
            mem[8'(addr + i)] = w[8*i +: 8];
    endtask

    task automatic set_result_flags(logic [31:0] r, int ri);
        zf = (r == 0);
        nf = (r & SIGN_BIT) != 0;
        regs[ri] = r;
    endtask

    task automatic execute(logic [5:0] op, logic [2:0] ri, logic [31:0] bd);
        logic [31:0] old, opnd, r, target;
        logic [2:0]  st;
        logic        take;
        exec_result_t res;
        st = STAT_OK;
        target = pc + PC_STEP;
        old = regs[ri];
        opnd = is_mem_form(op) ? read_word(bd) : bd;
        case (op)
            OP_LOAD_MEM, OP_LOAD_IMM: regs[ri] = opnd;
            OP_STORE: write_word(bd, old);
            OP_ADD_MEM, OP_ADD_IMM:
            begin
                r = old + opnd; vf = old > r; set_result_flags(r, ri);
            end
            OP_SUB_MEM, OP_SUB_IMM:
            begin
                r = old - opnd; vf = old < r; set_result_flags(r, ri);
            end
            OP_MUL_MEM, OP_MUL_IMM:
            begin
                r = old * opnd; vf = old > r; set_result_flags(r, ri);
            end
            OP_DIV_MEM, OP_DIV_IMM, OP_REM_MEM, OP_REM_IMM:
            begin
                if (opnd == 0)
                    st = STAT_DIV_ZERO;
                else
                begin
                    r = (op <= OP_DIV_IMM) ? old / opnd : old % opnd;
                    set_result_flags(r, ri);
                end
            end
            OP_SHL_MEM, OP_SHL_IMM:
                set_result_flags((opnd >= 32) ? 32'd0 : old << opnd[4:0], ri);
            OP_SHR_MEM, OP_SHR_IMM:
                set_result_flags((opnd >= 32) ? 32'd0 : old >> opnd[4:0], ri);
            OP_OR_MEM, OP_OR_IMM:   set_result_flags(old | opnd, ri);
            OP_AND_MEM, OP_AND_IMM: set_result_flags(old & opnd, ri);
            OP_XOR_MEM, OP_XOR_IMM: set_result_flags(old ^ opnd, ri);
            OP_NOT:                 set_result_flags(~old, ri);
            OP_CALL_MEM, OP_CALL_IMM, OP_CALLZ_MEM, OP_CALLZ_IMM,
            OP_CALLN_MEM, OP_CALLN_IMM:
            begin
                take = (op <= OP_CALL_IMM) || (op <= OP_CALLZ_IMM ? zf : nf);
                if (take)
                begin
                    if (sp >= STACK_LIMIT)
                        st = STAT_FULL;
                    else
                    begin
                        write_word(sp, pc + PC_STEP);
                        sp = sp + PTR_STEP;
                        target = opnd;
                    end
                end
            end
            OP_RET:
            begin
                if (sp <= STACK_BASE)
                    st = STAT_EMPTY;
                else
                begin
                    sp = sp - PTR_STEP;
                    target = read_word(sp);
                    write_word(sp, 0);
                end
            end
            OP_BR_MEM, OP_BR_IMM: target = opnd;
            OP_BRZ_MEM, OP_BRZ_IMM: if (zf) target = opnd;
            OP_HALT: st = STAT_HALTED;
            OP_CLR_FLAGS:
            begin
                zf = 0; nf = 0; vf = 0;
            end
            default: ;
        endcase
        if (st == STAT_OK)
            pc = target;
        res = '{st, pc, sp, zf, nf, vf, regs[ri]};
        expected_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t exp_res, got;
        if (!rst_n)
        begin
            foreach (regs[i]) regs[i] = 0;
            foreach (mem[i]) mem[i] = 0;
            pc = 0; sp = STACK_BASE; zf = 0; nf = 0; vf = 0;
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
            result_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                execute(opcode, reg_index, body);
            if (out_valid && out_ready)
            begin
                got = '{status, next_pc, stack_ptr, zero_flag, neg_flag, ovf_flag,
                        reg_value};
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: result transfer with nothing expected: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    // Input is sampled first in this edge, so the oldest entry
                    // is always the one that belongs to this result.
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: result %0d expected %p got %p",
                                     result_count, exp_res, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end
endmodule

// ----- sim/accumulator_isa_executor_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Executor testbench
// Drives directed and random instruction streams with random idling and
// back-pressure into the executor; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module accumulator_isa_executor_top_test;
    import acc_isa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [5:0]  opcode;
    logic [2:0]  reg_index;
    logic [31:0] body;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [7:0]  stack_ptr;
    logic        zero_flag;
    logic        neg_flag;
    logic        ovf_flag;
    logic [31:0] reg_value;
    int          fail_count;
    int          pending;
    int          result_count;
    int          sent;
    bit          calm;       // no idling on either side
    bit          hold_out;   // long receiver hold-off

    accumulator_isa_executor_top dut (.*);
    accumulator_isa_executor_checker checker_inst (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready <= 0;
                repeat (300) @(negedge clk);
                hold_out = 0;
            end
            out_ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    task automatic send(logic [5:0] op, logic [2:0] ri, logic [31:0] bd);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        opcode <= op;
        reg_index <= ri;
        body <= bd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_body();
        case ($urandom_range(5))
            0: return $urandom_range(255);
            1: return $urandom_range(40);
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            3: return 32'(1) << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drain();
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [5:0] op;
        in_valid = 0; opcode = 0; reg_index = 0; body = 0;
        rst_n = 0; calm = 0; hold_out = 0; sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;

        // Directed: extremes, flag and fault cases, stack limits.
        send(OP_LOAD_IMM, 3'd0, 32'hFFFF_FFFF);
        send(OP_ADD_IMM, 3'd0, 32'd1);
        send(OP_SUB_IMM, 3'd0, 32'd1);
        send(OP_MUL_IMM, 3'd0, 32'h8000_0001);
        send(OP_DIV_IMM, 3'd0, 32'd0);
        send(OP_REM_MEM, 3'd7, 32'd200);
        send(OP_SHL_IMM, 3'd0, 32'd32);
        send(OP_LOAD_IMM, 3'd7, 32'h8000_0000);
        send(OP_SHR_IMM, 3'd7, 32'd31);
        send(OP_STORE, 3'd7, 32'd254);
        send(OP_LOAD_MEM, 3'd1, 32'hFFFF_FFFE);
        send(OP_NOT, 3'd1, 32'd0);
        send(OP_CLR_FLAGS, 3'd0, 32'd0);
        send(OP_RET, 3'd0, 32'd0);
        for (int i = 0; i < 60; i++)
            send(OP_CALL_IMM, 3'($urandom), $urandom);
        send(OP_RET, 3'd2, 32'd0);
        send(OP_HALT, 3'd0, 32'd0);
        send(6'd63, 3'd0, 32'd0);
        send(OP_BRZ_IMM, 3'd0, 32'hFFFF_FFFC);
        for (int i = 0; i < 60; i++)
            send(OP_RET, 3'd0, 32'd0);

        // Receiver hold-off while the sender keeps offering.
        fork
            hold_out = 1;
        join_none
        for (int i = 0; i < 10; i++)
            send(OP_ADD_MEM, 3'($urandom), pick_body());
        wait_drain();

        for (int i = 0; i < 760; i++)
        begin
            calm = (i >= 400 && i < 500);
            op = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(37));
            // Halts stall nothing but waste items; keep them rare.
            if (op == OP_HALT && $urandom_range(3) != 0)
                op = OP_NOP;
            send(op, 3'($urandom), pick_body());
            if (i == 700)
                wait_drain();
        end
        calm = 0;
        wait_drain();
        repeat (100) @(negedge clk);

        $display("Sent %0d instructions covering all opcodes, stack limits and faults;",
                 sent);
        $display("checked %0d results with random idling and back-pressure.",
                 result_count);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/acc_isa_pkg.sv
hdl/acc_isa_ram.sv
hdl/acc_isa_div.sv
hdl/acc_isa_dp.sv
hdl/acc_isa_ctrl.sv
hdl/accumulator_isa_executor_top.sv
hdl/acc_isa_chk.sv
sim/accumulator_isa_executor_checker.sv
sim/accumulator_isa_executor_top_test.sv
